/* hw/rtl/tfbs_pkg.sv */
// ----------------------------------------------------------------------------
// tfbs_pkg
// shared widths, codes and types of the tabu filtered best selector
// ----------------------------------------------------------------------------
package tfbs_pkg;

  localparam int HASH_W  = 32;
  localparam int SCORE_W = 32;
  localparam int COUNT_W = 32;
  localparam int NBR_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int TABU_DEPTH_DEFAULT = 10;

  localparam logic [NBR_W-1:0]          NBR_RESET   = NBR_W'(50);
  localparam logic signed [SCORE_W-1:0] SCORE_GOAL_RESET = 32'sh7fff_ffff;
  localparam logic [COUNT_W-1:0]        TRIAL_CAP_RESET  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEIGHBOR_COUNT = 2'd0,
    CFG_SCORE_GOAL     = 2'd1,
    CFG_TRIAL_CAP      = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    STOP_RUNNING = 2'd0,
    STOP_ABORTED = 2'd1,
    STOP_SCORE   = 2'd2,
    STOP_TRIALS  = 2'd3
  } stop_reason_t;

  typedef enum logic {
    MODE_START     = 1'b0,
    MODE_CANDIDATE = 1'b1
  } mode_t;

  typedef struct packed {
    logic clear;
    logic write;
  } ring_ctl_t;

endpackage

/* hw/rtl/tfbs_ring.sv */
// ----------------------------------------------------------------------------
// tfbs_ring
// ring of recent committed hashes with parallel membership compare
// ----------------------------------------------------------------------------
module tfbs_ring #(
  parameter int TABU_DEPTH = tfbs_pkg::TABU_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tfbs_pkg::ring_ctl_t       ctl,
  input  logic [tfbs_pkg::HASH_W-1:0] wr_hash,
  input  logic [tfbs_pkg::HASH_W-1:0] query,
  output logic                      hit
);
  import tfbs_pkg::*;

  localparam int SLOT_W = (TABU_DEPTH > 1) ? $clog2(TABU_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_AFTER_SEED = SLOT_W'(1 % TABU_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST       = SLOT_W'(TABU_DEPTH - 1);

  logic [HASH_W-1:0]     entry [TABU_DEPTH];
  logic [TABU_DEPTH-1:0] entry_valid;
  logic [SLOT_W-1:0]     write_slot;
  logic [TABU_DEPTH-1:0] match;

  // invalid entries read as zero
  always_comb begin
    for (int k = 0; k < TABU_DEPTH; k++) begin
      match[k] = entry_valid[k] ? (entry[k] == query) : (query == '0);
    end
  end

  assign hit = |match;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      write_slot  <= SLOT_AFTER_SEED;
    end else if (ctl.clear) begin
      entry_valid    <= TABU_DEPTH'(1);
      write_slot     <= SLOT_AFTER_SEED;
    end else if (ctl.write) begin
      entry_valid[write_slot] <= 1'b1;
      write_slot <= (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      entry[0] <= wr_hash;
    end else if (ctl.write) begin
      entry[write_slot] <= wr_hash;
    end
  end

endmodule

/* hw/rtl/tabu_filtered_best_selector.sv */
// ----------------------------------------------------------------------------
// tabu_filtered_best_selector
// tabu search bookkeeping: ring of recent hashes, round best, stop rules
// ----------------------------------------------------------------------------
// Takes one transaction per clock when the output side does not stall, and returns
// one result transaction for each input, held first in the input register and
// then in the result register. An input register feeds a single result stage
// that holds the tabu ring compare
// (TABU_DEPTH parallel 32-bit equality tests), the signed score compare and
// the stop checks; the round state is updated in that same stage, so each
// candidate sees the effect of the one before it. s_tuser is the mode (0 seed,
// 1 candidate); m_tlast marks the transaction that closed a round. Config
// writes are taken at any time but must only be issued while the block is idle.
module tabu_filtered_best_selector #(
  parameter int TABU_DEPTH = tfbs_pkg::TABU_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // solution_hash[31:0], solution_score[63:32], abort_request[64], zero fill
  input  logic [71:0]                      s_tdata,
  // mode[0]
  input  logic [0:0]                       s_tuser,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // was_tabu[0], became_best[1], best_hash[33:2], best_score[65:34],
  // tests_done[97:66], finished[98], stop_reason[100:99], zero fill
  output logic [103:0]                     m_tdata,
  output logic                             m_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_wen,
  input  logic [tfbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tfbs_pkg::*;

  // config registers
  logic [NBR_W-1:0]          neighbor_count;
  logic signed [SCORE_W-1:0] score_goal;
  logic [COUNT_W-1:0]        trial_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= NBR_RESET;
      score_goal     <= SCORE_GOAL_RESET;
      trial_cap      <= TRIAL_CAP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[NBR_W-1:0];
        CFG_SCORE_GOAL:     score_goal     <= $signed(cfg_data[SCORE_W-1:0]);
        CFG_TRIAL_CAP:      trial_cap      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                      in_valid;
  mode_t                     in_mode;
  logic [HASH_W-1:0]         in_hash;
  logic signed [SCORE_W-1:0] in_score;
  logic                      in_abort;
  logic                      advance;
  logic                      fire;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode  <= mode_t'(s_tuser[0]);
      in_hash  <= s_tdata[31:0];
      in_score <= $signed(s_tdata[63:32]);
      in_abort <= s_tdata[64];
    end
  end

  // search state
  logic [NBR_W-1:0]          round_position;
  logic [HASH_W-1:0]         best_hash;
  logic signed [SCORE_W-1:0] best_score;
  logic [COUNT_W-1:0]        test_count;
  logic                      abort_pending;
  logic                      stopped;
  stop_reason_t              reason;

  logic [NBR_W-1:0]          round_position_next;
  logic [HASH_W-1:0]         best_hash_next;
  logic signed [SCORE_W-1:0] best_score_next;
  logic [COUNT_W-1:0]        test_count_next;
  logic                      abort_pending_next;
  logic                      stopped_next;
  stop_reason_t              reason_next;

  logic      start, active, first, hit, counted, better, take, close;
  logic      tabu;
  ring_ctl_t ring_ctl;

  tfbs_ring #(
    .TABU_DEPTH(TABU_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ring_ctl),
    .wr_hash (start ? in_hash : best_hash_next),
    .query   (in_hash),
    .hit     (hit)
  );

  always_comb begin
    start   = (in_mode == MODE_START);
    active  = !start && !stopped;
    first   = (round_position == '0);
    tabu    = active && !first && hit;
    counted = active && (first || !hit);
    better  = counted && !first && (in_score > best_score);
    take    = active && (first || better);
    close   = active && (first ? (neighbor_count == '0)
                               : (round_position >= neighbor_count));

    round_position_next = round_position;
    best_hash_next      = best_hash;
    best_score_next     = best_score;
    test_count_next     = test_count;
    abort_pending_next  = abort_pending;
    stopped_next        = stopped;
    reason_next         = reason;

    if (start) begin
      round_position_next = '0;
      best_hash_next      = in_hash;
      best_score_next     = in_score;
      test_count_next     = COUNT_W'(1);
      abort_pending_next  = in_abort;
      stopped_next        = 1'b0;
      reason_next         = STOP_RUNNING;
    end else if (active) begin
      abort_pending_next = abort_pending || in_abort;
      if (take) begin
        best_hash_next  = in_hash;
        best_score_next = in_score;
      end
      if (counted && (test_count != '1)) begin
        test_count_next = test_count + COUNT_W'(1);
      end
      if (close) begin
        round_position_next = '0;
        if (abort_pending_next) begin
          stopped_next = 1'b1;
          reason_next  = STOP_ABORTED;
        end else if (best_score_next >= score_goal) begin
          stopped_next = 1'b1;
          reason_next  = STOP_SCORE;
        end else if (test_count_next >= trial_cap) begin
          stopped_next = 1'b1;
          reason_next  = STOP_TRIALS;
        end
      end else begin
        round_position_next = round_position + NBR_W'(1);
      end
    end

    ring_ctl.clear = fire && start;
    ring_ctl.write = fire && close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_position <= '0;
      best_hash      <= '0;
      best_score     <= '0;
      test_count     <= '0;
      abort_pending  <= 1'b0;
      stopped        <= 1'b1;
      reason         <= STOP_RUNNING;
    end else if (fire) begin
      round_position <= round_position_next;
      best_hash      <= best_hash_next;
      best_score     <= best_score_next;
      test_count     <= test_count_next;
      abort_pending  <= abort_pending_next;
      stopped        <= stopped_next;
      reason         <= reason_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {3'b000, reason_next, stopped_next, test_count_next,
                  best_score_next, best_hash_next, take, tabu};
      m_tlast <= close;
    end
  end

endmodule
